/* hw/rtl/vsa_pkg.sv */
// vsa_pkg: shared types, constants and helpers for the voice slot allocator.
// No dependencies; used by vsa_slot_ram, vsa_ctrl and voice_slot_allocator_core.
package vsa_pkg;

   localparam int unsigned SLOTS   = 128;   // voice slots in the pool (1..128)
   localparam int unsigned IDX_W   = 7;     // slot index field width
   localparam int unsigned CNT_W   = 8;     // scan counter, holds SLOTS itself
   localparam int unsigned GEN_W   = 24;
   localparam int unsigned STAMP_W = 64;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 56;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   // operation codes carried on req_tuser
   localparam logic [2:0] MODE_ALLOC   = 3'd0;
   localparam logic [2:0] MODE_STOP    = 3'd1;
   localparam logic [2:0] MODE_CHECK   = 3'd2;
   localparam logic [2:0] MODE_FINISH  = 3'd3;
   localparam logic [2:0] MODE_STOPALL = 3'd4;

   typedef struct packed {
      logic               in_use;
      logic               loops;
      logic [GEN_W-1:0]   gen;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;

   localparam slot_entry_type RESET_ENTRY = '{
      in_use: 1'b0, loops: 1'b0, gen: GEN_W'(1), stamp: '0};

   typedef struct packed {
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      slot_entry_type       wr_data;
   } ram_req_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [31:0]      handle;
      logic             loop_flag;
      logic             start_ok;
      logic [IDX_W-1:0] end_slot;
   } req_item_type;

   typedef struct packed {
      logic             status;
      logic [31:0]      new_handle;
      logic [IDX_W-1:0] slot_index;
      logic             evicted;
      logic [IDX_W-1:0] evicted_slot;
      logic [7:0]       active_count;
   } rsp_item_type;

   // next generation after a release; zero is never handed out
   function automatic logic [GEN_W-1:0] gen_next(input logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] n;
      n = g + GEN_W'(1);
      return (n == '0) ? GEN_W'(1) : n;
   endfunction

endpackage

/* hw/rtl/vsa_slot_ram.sv */
// vsa_slot_ram: per-slot state memory, one write and one registered read per cycle.
// Per-entry valid flops make unwritten entries read as the reset entry.
// Depends on vsa_pkg.
module vsa_slot_ram (
   input  logic                    clock,
   input  logic                    reset,
   input  vsa_pkg::ram_req_type    ram_req,
   output vsa_pkg::slot_entry_type rd_data
);

   vsa_pkg::slot_entry_type slot_mem [vsa_pkg::SLOTS];
   vsa_pkg::slot_entry_type rd_q_ff;
   logic                    rd_valid_ff;
   logic [vsa_pkg::SLOTS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         slot_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_q_ff     <= slot_mem[ram_req.rd_addr];
         rd_valid_ff <= valid_ff[ram_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_req.wr_en) begin
         valid_ff[ram_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : vsa_pkg::RESET_ENTRY;

endmodule

/* hw/rtl/vsa_ctrl.sv */
// vsa_ctrl: sequencer for allocate / stop / check / finish / stop-all requests.
// Scans and rewrites slot state through vsa_slot_ram. Depends on vsa_pkg.
module vsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  vsa_pkg::req_item_type   req_item,
   output logic                    req_ready,
   output logic                    res_valid,
   output vsa_pkg::rsp_item_type   res,
   input  logic                    res_take,
   output vsa_pkg::ram_req_type    ram_req,
   input  vsa_pkg::slot_entry_type rd_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_EVICT  = 6'b001000,
      ST_SWEEP  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   vsa_pkg::req_item_type             item_ff, item_in;
   logic [vsa_pkg::IDX_W-1:0]         idx_ff, idx_in;       // index of data on rd_data
   logic [vsa_pkg::CNT_W-1:0]         cnt_ff, cnt_in;       // next scan address
   vsa_pkg::slot_entry_type           vic_ff, vic_in;
   logic [vsa_pkg::IDX_W-1:0]         vic_idx_ff, vic_idx_in;
   vsa_pkg::rsp_item_type             res_ff, res_in;
   logic [7:0]                        used_ff, used_in;
   logic [vsa_pkg::STAMP_W-1:0]       stamp_ff, stamp_in;

   vsa_pkg::slot_entry_type           e;
   vsa_pkg::slot_entry_type           freed;
   vsa_pkg::slot_entry_type           cand;
   logic [vsa_pkg::STAMP_W-1:0]       stamp_next;
   logic [vsa_pkg::GEN_W-1:0]         vic_gen_n;
   logic [7:0]                        low;
   logic                              better;

   assign e          = rd_data;
   assign stamp_next = stamp_ff + vsa_pkg::STAMP_W'(1);
   assign low        = req_item.handle[7:0];
   assign vic_gen_n  = vsa_pkg::gen_next(vic_ff.gen);

   always_comb begin
      freed     = e;
      freed.in_use = 1'b0;
      freed.gen = vsa_pkg::gen_next(e.gen);
   end

   // victim order: one-shots before loops, then the older stamp; ties keep lower slot
   always_comb begin
      if (e.loops != vic_ff.loops) begin
         better = !e.loops;
      end else begin
         better = e.stamp < vic_ff.stamp;
      end
      cand = ((idx_ff == '0) || better) ? e : vic_ff;
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      vic_in     = vic_ff;
      vic_idx_in = vic_idx_ff;
      res_in     = res_ff;
      used_in    = used_ff;
      stamp_in   = stamp_ff;
      ram_req    = '0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            res_in    = '0;
            res_in.status = 1'b1;
            if (req_valid) begin
               item_in = req_item;
               unique case (req_item.mode) inside
                  vsa_pkg::MODE_ALLOC, vsa_pkg::MODE_STOPALL: begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = '0;
                     idx_in   = '0;
                     cnt_in   = vsa_pkg::CNT_W'(1);
                     state_in = (req_item.mode == vsa_pkg::MODE_ALLOC) ? ST_SCAN : ST_SWEEP;
                  end
                  vsa_pkg::MODE_STOP, vsa_pkg::MODE_CHECK: begin
                     if ((low != 8'd0) && (low <= vsa_pkg::SLOTS_CNT)) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = vsa_pkg::IDX_W'(low - 8'd1);
                        idx_in   = vsa_pkg::IDX_W'(low - 8'd1);
                        state_in = ST_LOOKUP;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  vsa_pkg::MODE_FINISH: begin
                     if ({1'b0, req_item.end_slot} < vsa_pkg::SLOTS_CNT) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = req_item.end_slot;
                        idx_in   = req_item.end_slot;
                        state_in = ST_LOOKUP;
                     end else begin
                        res_in.slot_index = req_item.end_slot;
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_LOOKUP: begin
            if (item_ff.mode == vsa_pkg::MODE_FINISH) begin
               res_in.slot_index = item_ff.end_slot;
               if (e.in_use && !e.loops) begin
                  res_in.status   = 1'b0;
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = idx_ff;
                  ram_req.wr_data = freed;
                  used_in = used_ff - 8'd1;
               end
            end else if (e.in_use && (e.gen == item_ff.handle[31:8])) begin
               res_in.status     = 1'b0;
               res_in.slot_index = idx_ff;
               if (item_ff.mode == vsa_pkg::MODE_STOP) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = idx_ff;
                  ram_req.wr_data = freed;
                  used_in = used_ff - 8'd1;
               end
            end
            state_in = ST_DONE;
         end

         ST_SCAN: begin
            if (cnt_ff < vsa_pkg::SLOTS_CNT) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cnt_ff[vsa_pkg::IDX_W-1:0];
               idx_in = cnt_ff[vsa_pkg::IDX_W-1:0];
               cnt_in = cnt_ff + vsa_pkg::CNT_W'(1);
            end
            if (!e.in_use) begin
               // lowest free slot found
               res_in.slot_index = idx_ff;
               res_in.status     = !item_ff.start_ok;
               if (item_ff.start_ok) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = idx_ff;
                  ram_req.wr_data = '{in_use: 1'b1, loops: item_ff.loop_flag,
                                      gen: e.gen, stamp: stamp_next};
                  stamp_in = stamp_next;
                  used_in  = used_ff + 8'd1;
                  res_in.new_handle = {e.gen, ({1'b0, idx_ff} + 8'd1)};
               end
               state_in = ST_DONE;
            end else begin
               vic_in = cand;
               if ((idx_ff == '0) || better) begin
                  vic_idx_in = idx_ff;
               end
               if (idx_ff == vsa_pkg::LAST_IDX) begin
                  state_in = ST_EVICT;
               end
            end
         end

         ST_EVICT: begin
            res_in.slot_index   = vic_idx_ff;
            res_in.evicted      = 1'b1;
            res_in.evicted_slot = vic_idx_ff;
            res_in.status       = !item_ff.start_ok;
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = vic_idx_ff;
            if (item_ff.start_ok) begin
               // victim freed and reused at once: count unchanged
               ram_req.wr_data = '{in_use: 1'b1, loops: item_ff.loop_flag,
                                   gen: vic_gen_n, stamp: stamp_next};
               stamp_in = stamp_next;
               res_in.new_handle = {vic_gen_n, ({1'b0, vic_idx_ff} + 8'd1)};
            end else begin
               ram_req.wr_data = '{in_use: 1'b0, loops: vic_ff.loops,
                                   gen: vic_gen_n, stamp: vic_ff.stamp};
               used_in = used_ff - 8'd1;
            end
            state_in = ST_DONE;
         end

         ST_SWEEP: begin
            if (cnt_ff < vsa_pkg::SLOTS_CNT) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cnt_ff[vsa_pkg::IDX_W-1:0];
               idx_in = cnt_ff[vsa_pkg::IDX_W-1:0];
               cnt_in = cnt_ff + vsa_pkg::CNT_W'(1);
            end
            if (e.in_use) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = idx_ff;
               ram_req.wr_data = freed;
               used_in = used_ff - 8'd1;
            end
            if (idx_ff == vsa_pkg::LAST_IDX) begin
               res_in.status = 1'b0;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res = res_ff;
      res.active_count = used_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         stamp_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         stamp_ff <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      vic_ff     <= vic_in;
      vic_idx_ff <= vic_idx_in;
      res_ff     <= res_in;
   end

endmodule

/* hw/rtl/voice_slot_allocator_core.sv */
// voice_slot_allocator_core: top level of the voice slot allocator.
// Holds the response register; instantiates vsa_ctrl and vsa_slot_ram. Depends on vsa_pkg.
//
// Usage
//   req_*  : one request per operation; req_tuser carries the mode (allocate, stop
//            handle, check handle, finished report, stop all). A request is taken
//            when req_tvalid and req_tready are both high.
//   rsp_*  : exactly one response per request, in request order; rsp_tuser is the
//            status flag (0 success, 1 stale handle / not committed / nothing freed).
//   Requests are processed one at a time. Slot state lives in a single-port-read
//   memory with a registered read, so the cost is set by the slot scan:
//     allocate     : slots are read from 0 upward until the lowest free one,
//                    or all SLOTS are read and a victim is cut when every slot is busy
//     stop / check / finished report : one slot read (none when the handle is malformed)
//     stop all     : every slot in turn, one slot read and rewritten per cycle
//   A new request is taken as soon as the previous response sits in the output register.
//   Reset (synchronous, active high) empties the pool: all slots free, all
//   generations 1, count and stamp counter 0. It takes effect at once.
//   When rsp_tready is low the response holds in the output register; the next
//   request may run but its result waits until the register drains.
module voice_slot_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // {pad[47:41], end_slot[40:34], start_ok[33], loop_flag[32], handle[31:0]}
   input  logic [vsa_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [2:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // {pad[55], active_count[54:47], evicted_slot[46:40], evicted[39],
   //  slot_index[38:32], new_handle[31:0]}
   output logic [vsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[0]
   output logic                           rsp_tuser
);

   vsa_pkg::req_item_type   req_item;
   vsa_pkg::rsp_item_type   res;
   vsa_pkg::ram_req_type    ram_req;
   vsa_pkg::slot_entry_type rd_data;
   logic                    res_valid;
   logic                    res_take;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [vsa_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                           rsp_user_ff, rsp_user_in;

   // unpack request payload
   always_comb begin
      req_item.mode      = req_tuser;
      req_item.handle    = req_tdata[31:0];
      req_item.loop_flag = req_tdata[32];
      req_item.start_ok  = req_tdata[33];
      req_item.end_slot  = req_tdata[40:34];
   end

   // output register frees up when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {1'b0, res.active_count, res.evicted_slot, res.evicted,
                           res.slot_index, res.new_handle};
            rsp_user_in = res.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   vsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_item  (req_item),
      .req_ready (req_tready),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   vsa_slot_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule
